// ===== rtl/core/csr_spmv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csr_spmv_pkg
// Shared constants and types for the CSR sparse matrix-vector multiplier.
// ----------------------------------------------------------------------------
package csr_spmv_pkg;

    localparam int VECTOR_DEPTH   = 4096;
    localparam int VEC_ADDR_W     = $clog2(VECTOR_DEPTH);
    localparam int ROW_INDEX_BITS = 16;

    // index zero-extended wide enough to compare against any depth
    localparam int IDX_WIDE_W = 17;

    localparam logic [12:0] COLS_RESET = 13'd4096;

    typedef enum logic [1:0] {
        FUNC_VEC_WR    = 2'd0,
        FUNC_NONZERO   = 2'd1,
        FUNC_EMPTY_ROW = 2'd2
    } t_func;

    typedef logic [ROW_INDEX_BITS-1:0] t_row_cnt;

    // control that rides along with one beat into the multiply-accumulate
    typedef struct packed {
        logic nonzero;
        logic col_ok;
        logic emit;
    } t_mac_op;

endpackage
`default_nettype wire

// ===== rtl/core/csr_spmv_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csr_spmv_mac
// Multiply stage, saturating row accumulator and registered result beat.
// ----------------------------------------------------------------------------
module csr_spmv_mac (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire csr_spmv_pkg::t_mac_op  i_op,
    input  wire logic signed [31:0]     i_mat,
    input  wire logic signed [31:0]     i_vec,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [15:0]                 o_row_index,
    output logic signed [63:0]          o_row_sum,
    output logic                        o_column_error
);
    import csr_spmv_pkg::*;

    logic               r_s2_valid;
    t_mac_op            r_s2_op;
    logic signed [63:0] r_s2_prod;

    logic signed [63:0] r_acc;
    logic signed [63:0] n_acc;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_acc_upd;
    logic               r_err;
    logic               n_err;
    logic               w_err_upd;
    t_row_cnt           r_row_cnt;
    t_row_cnt           n_row_cnt;
    logic [31:0]        w_row_wide;

    logic               r_out_valid;
    logic               n_out_valid;
    logic [15:0]        r_out_row;
    logic signed [63:0] r_out_sum;
    logic               r_out_err;

    logic               w_go;
    logic               w_fire;

    // an emitting beat waits only for room in the result register
    assign w_go    = !r_s2_op.emit || !r_out_valid || i_out_ready;
    assign o_ready = !r_s2_valid || w_go;
    assign w_fire  = r_s2_valid && w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_ready) begin
            r_s2_valid <= i_valid;
        end
    end

    // 32x32 signed product; zero when the beat adds nothing to the row
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2_op   <= i_op;
            r_s2_prod <= (i_op.nonzero && i_op.col_ok) ? 64'(i_mat) * 64'(i_vec) : '0;
        end
    end

    // saturating add of the product
    always_comb begin
        w_sum = r_acc + r_s2_prod;
        if (r_acc[63] == r_s2_prod[63] && w_sum[63] != r_acc[63]) begin
            w_sum = r_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

    assign w_acc_upd  = (r_s2_op.nonzero && r_s2_op.col_ok) ? w_sum : r_acc;
    assign w_err_upd  = r_err | (r_s2_op.nonzero & ~r_s2_op.col_ok);
    assign w_row_wide = 32'(r_row_cnt);

    always_comb begin
        n_acc       = r_acc;
        n_err       = r_err;
        n_row_cnt   = r_row_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_fire) begin
            if (r_s2_op.emit) begin
                n_acc       = '0;
                n_err       = 1'b0;
                n_row_cnt   = r_row_cnt + t_row_cnt'(1);
                n_out_valid = 1'b1;
            end else begin
                n_acc = w_acc_upd;
                n_err = w_err_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_err       <= n_err;
            r_row_cnt   <= n_row_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_s2_op.emit) begin
            r_out_row <= w_row_wide[15:0];
            r_out_sum <= w_acc_upd;
            r_out_err <= w_err_upd;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_index    = r_out_row;
    assign o_row_sum      = r_out_sum;
    assign o_column_error = r_out_err;

`ifndef SYNTH
    a_emit_clears_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_s2_op.emit |=> r_out_valid && r_acc == '0 && !r_err)
        else $error("row state not cleared after emit");

    a_emit_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_s2_op.emit |=> r_row_cnt == $past(r_row_cnt) + t_row_cnt'(1))
        else $error("row counter did not advance on emit");

    a_stall_holds_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !w_go |=> r_s2_valid && $stable(r_s2_prod) && $stable(r_acc))
        else $error("product stage or accumulator moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/csr_sparse_matrix_vector_multiply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// Pipeline: vector read, multiply, then accumulate into the result register;
//   each step is registered and holds while the result side stalls.
// Throughput: one item per cycle while the result side accepts; the vector store
//   read port and the single accumulator each take one nonzero per cycle.
// Reset: synchronous, active low; clears accumulator, flag, row counter and
//   sets r_cols to 4096. The vector store is not cleared.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [12:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_func,
    input  wire logic [11:0]        i_index,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_row_end,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [15:0]             o_row_index,
    output logic signed [63:0]      o_row_sum,
    output logic                    o_column_error
);
    import csr_spmv_pkg::*;

    logic [31:0]            r_vec_mem [VECTOR_DEPTH];
    logic signed [31:0]     r_rd_data;
    logic [12:0]            r_cols;

    logic                   r_s1_valid;
    t_mac_op                r_s1_op;
    logic signed [31:0]     r_s1_value;

    logic [IDX_WIDE_W-1:0]  w_idx_wide;
    logic [VEC_ADDR_W-1:0]  w_addr;
    logic                   w_in_range;
    logic                   w_in_fire;
    logic                   w_mac_ready;
    logic                   w_to_mac;
    logic                   w_vec_wr;
    t_mac_op                w_op;

    assign w_idx_wide = IDX_WIDE_W'(i_index);
    assign w_addr     = w_idx_wide[VEC_ADDR_W-1:0];
    assign w_in_range = w_idx_wide < IDX_WIDE_W'(VECTOR_DEPTH);

    assign o_in_ready = !r_s1_valid || w_mac_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_comb begin
        w_to_mac   = 1'b0;
        w_vec_wr   = 1'b0;
        w_op       = '0;
        w_op.col_ok = w_in_range && ({1'b0, i_index} < r_cols);
        case (t_func'(i_func))
            FUNC_VEC_WR: begin
                w_vec_wr = w_in_range;
            end
            FUNC_NONZERO: begin
                w_to_mac     = 1'b1;
                w_op.nonzero = 1'b1;
                w_op.emit    = i_row_end;
            end
            FUNC_EMPTY_ROW: begin
                w_to_mac  = 1'b1;
                w_op.emit = 1'b1;
            end
            default: begin
                w_to_mac = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols     <= COLS_RESET;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cols <= i_cfg_wdata;
            end
            if (w_in_fire) begin
                r_s1_valid <= w_to_mac;
            end else if (w_mac_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_op    <= w_op;
            r_s1_value <= i_value;
        end
    end

    // vector store: at most one write or one read per accepted beat
    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_vec_wr) begin
            r_vec_mem[w_addr] <= i_value;
        end
        if (w_in_fire && w_op.nonzero) begin
            r_rd_data <= r_vec_mem[w_addr];
        end
    end

    csr_spmv_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_s1_valid),
        .o_ready        (w_mac_ready),
        .i_op           (r_s1_op),
        .i_mat          (r_s1_value),
        .i_vec          (r_rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_row_index    (o_row_index),
        .o_row_sum      (o_row_sum),
        .o_column_error (o_column_error)
    );

endmodule
`default_nettype wire
